>>> sv/trace_state_stack_channel_top_defines.svh
// assertion macros for the trace state stack channel
// used by trace_state_stack_channel_top; expects clk and rst in scope
`ifndef TRACE_STATE_STACK_CHANNEL_TOP_DEFINES_SVH
`define TRACE_STATE_STACK_CHANNEL_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define TSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define TSSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TSSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSSC_ASSERT(lbl, prop, msg)
`define TSSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TSSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/tssc_pkg.sv
// shared types and constants for the trace state stack channel
// no dependencies; used by tssc_core and trace_state_stack_channel_top
`timescale 1ns / 1ps

package tssc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int STATE_W     = 15;
  localparam int VALUE_W     = 16;
  localparam int TS_W        = 63;
  localparam int TIME_W      = 64;
  localparam int ROW_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // reset values of the configuration registers
  localparam logic [STATE_W-1:0] RST_BAD_STATE       = '0;
  localparam logic [STATE_W-1:0] RST_INITIAL_STATE   = '0;
  localparam logic               RST_INITIAL_ENABLED = 1'b1;
  localparam logic               RST_INITIAL_DIRTY   = 1'b0;
  localparam logic [ROW_W-1:0]   RST_TRACE_ROW       = '0;
  localparam logic [ROW_W-1:0]   RST_TRACE_TYPE      = '0;

  typedef enum logic [2:0] {
    ACT_ENABLE  = 3'd0,
    ACT_DISABLE = 3'd1,
    ACT_SET     = 3'd2,
    ACT_PUSH    = 3'd3,
    ACT_POP     = 3'd4,
    ACT_EVENT   = 3'd5,
    ACT_EMIT    = 3'd6
  } tssc_act_e;

  typedef enum logic [3:0] {
    ERR_OK          = 4'd0,
    ERR_DISABLED    = 4'd1,
    ERR_BAD_VALUE   = 4'd2,
    ERR_DIRTY       = 4'd3,
    ERR_REPEAT      = 4'd4,
    ERR_FULL        = 4'd5,
    ERR_EMPTY       = 4'd6,
    ERR_MISMATCH    = 4'd7,
    ERR_SAME_ENABLE = 4'd8,
    ERR_EV_DISABLED = 4'd9
  } tssc_err_e;

  typedef enum logic [2:0] {
    DIRTY_CLEAN  = 3'b001,
    DIRTY_ACTIVE = 3'b010,
    DIRTY_VALUE  = 3'b100
  } tssc_dirty_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAD_STATE       = 3'd0,
    CFG_INITIAL_STATE   = 3'd1,
    CFG_INITIAL_ENABLED = 3'd2,
    CFG_INITIAL_DIRTY   = 3'd3,
    CFG_TRACE_ROW       = 3'd4,
    CFG_TRACE_TYPE      = 3'd5
  } tssc_cfg_idx_e;

  typedef enum logic [1:0] {
    SOP_NONE = 2'd0,
    SOP_SET  = 2'd1,
    SOP_PUSH = 2'd2,
    SOP_POP  = 2'd3
  } tssc_sop_e;

  typedef struct packed {
    logic [STATE_W-1:0] bad_state;
    logic [STATE_W-1:0] initial_state;
    logic               initial_enabled;
    logic               initial_dirty;
    logic [ROW_W-1:0]   trace_row;
    logic [ROW_W-1:0]   trace_type;
  } tssc_cfg_t;

  // all results of one item: an ack, one record, or two records
  typedef struct packed {
    logic               two;
    logic               is_record;
    tssc_err_e          err;
    logic [STATE_W-1:0] cur;
    logic [TIME_W-1:0]  t0;
    logic [STATE_W-1:0] s0;
    logic [TIME_W-1:0]  t1;
    logic [STATE_W-1:0] s1;
  } tssc_res_t;

endpackage

>>> sv/trace_state_stack_channel_top.sv
// Trace state stack channel, top level.
// Channels: in (action, state_value, timestamp) with in_valid/in_ready;
// out (is_record, error_code, current_state, record_*, last_result) with
// out_valid/out_ready; cfg (cfg_index, cfg_data) with cfg_valid/cfg_ready.
// An accepted beat is held in an input register and processed, once the
// result queue has room, in one pass against the channel state; its results
// are registered into a two-entry result queue, which drives the output.
// Every action gives one beat; an emit gives one or two beats, the last
// marked by last_result. One item per cycle is accepted while the receiver
// keeps up; a two-record emit holds the queue head until both its beats go.
// When the receiver stalls the queue absorbs two items, then the input
// register holds one more and in_ready drops.
// cfg_ready is high only while nothing is in flight: the input register and
// the result queue are empty. Writing initial_state, initial_enabled or
// initial_dirty reloads the channel.
// Reset (rst, synchronous) loads register defaults and the initial channel
// state, and empties the input register and the result queue.
// Depends on tssc_pkg, tssc_core and trace_state_stack_channel_top_defines.svh.
`timescale 1ns / 1ps
`include "trace_state_stack_channel_top_defines.svh"

module trace_state_stack_channel_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           action,
  input  logic signed [tssc_pkg::VALUE_W-1:0]  state_value,
  input  logic [tssc_pkg::TS_W-1:0]            timestamp,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 is_record,
  output logic [3:0]                           error_code,
  output logic [tssc_pkg::STATE_W-1:0]         current_state,
  output logic signed [tssc_pkg::TIME_W-1:0]   record_time,
  output logic [tssc_pkg::STATE_W-1:0]         record_state,
  output logic [tssc_pkg::ROW_W-1:0]           record_row,
  output logic [tssc_pkg::ROW_W-1:0]           record_type,
  output logic                                 last_result,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tssc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tssc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tssc_pkg::tssc_cfg_t cfg;
  tssc_pkg::tssc_cfg_t cfg_next;
  logic                cfg_wr;
  logic                reload;

  logic                              s1_valid;
  logic [2:0]                        s1_action;
  logic signed [tssc_pkg::VALUE_W-1:0] s1_value;
  logic [tssc_pkg::TS_W-1:0]         s1_ts;
  logic                              s1_fire;

  tssc_pkg::tssc_res_t core_res;
  tssc_pkg::tssc_res_t res_mem [2];
  tssc_pkg::tssc_res_t head;
  logic                out_wptr;
  logic                out_rptr;
  logic [1:0]          out_cnt;
  logic                out_sub;
  logic                out_beat;
  logic                out_pop;

  // configuration registers
  assign cfg_ready = !s1_valid && (out_cnt == 2'd0);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign reload    = cfg_wr && (cfg_index == tssc_pkg::CFG_INITIAL_STATE ||
                                cfg_index == tssc_pkg::CFG_INITIAL_ENABLED ||
                                cfg_index == tssc_pkg::CFG_INITIAL_DIRTY);

  always_comb begin
    cfg_next = cfg;
    if (rst) begin
      cfg_next.bad_state       = tssc_pkg::RST_BAD_STATE;
      cfg_next.initial_state   = tssc_pkg::RST_INITIAL_STATE;
      cfg_next.initial_enabled = tssc_pkg::RST_INITIAL_ENABLED;
      cfg_next.initial_dirty   = tssc_pkg::RST_INITIAL_DIRTY;
      cfg_next.trace_row       = tssc_pkg::RST_TRACE_ROW;
      cfg_next.trace_type      = tssc_pkg::RST_TRACE_TYPE;
    end else if (cfg_wr) begin
      case (tssc_pkg::tssc_cfg_idx_e'(cfg_index))
        tssc_pkg::CFG_BAD_STATE:
          cfg_next.bad_state = cfg_data[tssc_pkg::STATE_W-1:0];
        tssc_pkg::CFG_INITIAL_STATE:
          cfg_next.initial_state = cfg_data[tssc_pkg::STATE_W-1:0];
        tssc_pkg::CFG_INITIAL_ENABLED:
          cfg_next.initial_enabled = cfg_data[0];
        tssc_pkg::CFG_INITIAL_DIRTY:
          cfg_next.initial_dirty = cfg_data[0];
        tssc_pkg::CFG_TRACE_ROW:
          cfg_next.trace_row = cfg_data;
        tssc_pkg::CFG_TRACE_TYPE:
          cfg_next.trace_type = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  // input register
  assign s1_fire  = s1_valid && ((out_cnt < 2'd2) || out_pop);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_value  <= state_value;
      s1_ts     <= timestamp;
    end
  end

  tssc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .reload      (reload),
    .ld          (cfg_next),
    .bad_state   (cfg.bad_state),
    .fire        (s1_fire),
    .action      (s1_action),
    .state_value (s1_value),
    .timestamp   (s1_ts),
    .res         (core_res)
  );

  // result queue, one entry per item
  assign head      = res_mem[out_rptr];
  assign out_valid = (out_cnt != 2'd0);
  assign out_beat  = out_valid && out_ready;
  assign out_pop   = out_beat && last_result;

  always_ff @(posedge clk) begin
    if (s1_fire) res_mem[out_wptr] <= core_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr <= 1'b0;
      out_rptr <= 1'b0;
      out_cnt  <= 2'd0;
      out_sub  <= 1'b0;
    end else begin
      if (s1_fire) out_wptr <= !out_wptr;
      if (out_pop) out_rptr <= !out_rptr;
      if (out_beat) out_sub <= !last_result;
      out_cnt <= out_cnt + {1'b0, s1_fire} - {1'b0, out_pop};
    end
  end

  // output beat fields
  assign is_record     = head.is_record;
  assign error_code    = head.err;
  assign current_state = head.cur;
  assign record_time   = out_sub ? head.t1 : head.t0;
  assign record_state  = out_sub ? head.s1 : head.s0;
  assign record_row    = head.is_record ? cfg.trace_row : '0;
  assign record_type   = head.is_record ? cfg.trace_type : '0;
  assign last_result   = !head.two || out_sub;

  // checks
  `TSSC_ASSERT(a_queue_bound, out_cnt <= 2'd2, "result queue holds more than two items")
  `TSSC_ASSERT_NEXT(a_pair_second, out_beat && !last_result, out_valid && out_sub, "second record beat missing")
  `TSSC_ASSERT_IMPL(a_ack_empty, out_valid && !is_record, record_time == '0 && record_state == '0 && record_row == '0, "ack beat carries record data")

endmodule

>>> sv/tssc_core.sv
// channel state (state stack, flags, pending event, last emitted) and action logic
// depends on tssc_pkg; results of one item are formed in one pass
`timescale 1ns / 1ps

module tssc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          reload,
  input  tssc_pkg::tssc_cfg_t           ld,
  input  logic [tssc_pkg::STATE_W-1:0]  bad_state,
  input  logic                          fire,
  input  logic [2:0]                    action,
  input  logic signed [tssc_pkg::VALUE_W-1:0] state_value,
  input  logic [tssc_pkg::TS_W-1:0]     timestamp,
  output tssc_pkg::tssc_res_t           res
);

  // stack kept with the top at entry zero so top and below sit at fixed places
  logic [tssc_pkg::STATE_W-1:0] stack [tssc_pkg::STACK_DEPTH];
  logic [tssc_pkg::DEPTH_W-1:0] depth;
  logic                         enabled;
  tssc_pkg::tssc_dirty_e        dirty;
  logic                         pv;
  logic [tssc_pkg::STATE_W-1:0] pe;
  logic [tssc_pkg::TS_W-1:0]    ct;
  logic                         lev;
  logic [tssc_pkg::STATE_W-1:0] le;

  logic [tssc_pkg::DEPTH_W-1:0] depth_next;
  logic                         enabled_next;
  tssc_pkg::tssc_dirty_e        dirty_next;
  logic                         pv_next;
  logic [tssc_pkg::STATE_W-1:0] pe_next;
  logic [tssc_pkg::TS_W-1:0]    ct_next;
  logic                         lev_next;
  logic [tssc_pkg::STATE_W-1:0] le_next;
  tssc_pkg::tssc_sop_e          sop;
  tssc_pkg::tssc_err_e          err;

  logic [tssc_pkg::STATE_W-1:0] v15;
  logic                         v_neg;
  logic                         v_pos;
  logic                         le_hit_v;
  logic [tssc_pkg::STATE_W-1:0] below;
  logic [tssc_pkg::STATE_W-1:0] top_st;
  logic [tssc_pkg::STATE_W-1:0] top_new;
  logic                         rec_ev;
  logic                         rec_st;
  logic [tssc_pkg::TIME_W-1:0]  t_st;
  logic [tssc_pkg::TIME_W-1:0]  t_ev;

  // operand decode
  assign v15      = state_value[tssc_pkg::STATE_W-1:0];
  assign v_neg    = state_value[tssc_pkg::VALUE_W-1];
  assign v_pos    = !v_neg && (state_value != '0);
  assign le_hit_v = lev && (le == v15);
  assign below    = (depth >= tssc_pkg::DEPTH_W'(2)) ? stack[1] : '0;
  assign top_st   = !enabled ? bad_state :
                    (depth == '0) ? '0 : stack[0];
  assign t_st     = {1'b0, ct};
  assign t_ev     = t_st - tssc_pkg::TIME_W'(1);

  // action decode and next state
  always_comb begin
    depth_next   = depth;
    enabled_next = enabled;
    dirty_next   = dirty;
    pv_next      = pv;
    pe_next      = pe;
    ct_next      = ct;
    lev_next     = lev;
    le_next      = le;
    sop          = tssc_pkg::SOP_NONE;
    err          = tssc_pkg::ERR_OK;
    rec_ev       = 1'b0;
    rec_st       = 1'b0;
    case (tssc_pkg::tssc_act_e'(action))
      tssc_pkg::ACT_ENABLE, tssc_pkg::ACT_DISABLE: begin
        if (enabled == (action == tssc_pkg::ACT_ENABLE)) begin
          err = tssc_pkg::ERR_SAME_ENABLE;
        end else begin
          enabled_next = (action == tssc_pkg::ACT_ENABLE);
          ct_next      = timestamp;
          if (dirty == tssc_pkg::DIRTY_CLEAN) dirty_next = tssc_pkg::DIRTY_ACTIVE;
        end
      end
      tssc_pkg::ACT_SET: begin
        if (!enabled) err = tssc_pkg::ERR_DISABLED;
        else if (v_neg) err = tssc_pkg::ERR_BAD_VALUE;
        else if (dirty != tssc_pkg::DIRTY_ACTIVE && le_hit_v) err = tssc_pkg::ERR_REPEAT;
        else begin
          sop     = tssc_pkg::SOP_SET;
          ct_next = timestamp;
          if (depth == '0) depth_next = tssc_pkg::DEPTH_W'(1);
          if (dirty == tssc_pkg::DIRTY_CLEAN) dirty_next = tssc_pkg::DIRTY_VALUE;
        end
      end
      tssc_pkg::ACT_PUSH: begin
        if (!enabled) err = tssc_pkg::ERR_DISABLED;
        else if (!v_pos) err = tssc_pkg::ERR_BAD_VALUE;
        else if (dirty != tssc_pkg::DIRTY_CLEAN) err = tssc_pkg::ERR_DIRTY;
        else if (le_hit_v) err = tssc_pkg::ERR_REPEAT;
        else if (depth >= tssc_pkg::DEPTH_W'(tssc_pkg::STACK_DEPTH)) err = tssc_pkg::ERR_FULL;
        else begin
          sop        = tssc_pkg::SOP_PUSH;
          depth_next = depth + tssc_pkg::DEPTH_W'(1);
          ct_next    = timestamp;
          dirty_next = tssc_pkg::DIRTY_VALUE;
        end
      end
      tssc_pkg::ACT_POP: begin
        if (!enabled) err = tssc_pkg::ERR_DISABLED;
        else if (dirty != tssc_pkg::DIRTY_CLEAN) err = tssc_pkg::ERR_DIRTY;
        else if (depth == '0) err = tssc_pkg::ERR_EMPTY;
        else if (!v_neg && stack[0] != v15) err = tssc_pkg::ERR_MISMATCH;
        else if (lev && le == below) err = tssc_pkg::ERR_REPEAT;
        else begin
          sop        = tssc_pkg::SOP_POP;
          depth_next = depth - tssc_pkg::DEPTH_W'(1);
          ct_next    = timestamp;
          dirty_next = tssc_pkg::DIRTY_VALUE;
        end
      end
      tssc_pkg::ACT_EVENT: begin
        if (!enabled) err = tssc_pkg::ERR_DISABLED;
        else if (dirty != tssc_pkg::DIRTY_CLEAN) err = tssc_pkg::ERR_DIRTY;
        else if (!v_pos) err = tssc_pkg::ERR_BAD_VALUE;
        else if (le_hit_v) err = tssc_pkg::ERR_REPEAT;
        else begin
          pv_next    = 1'b1;
          pe_next    = v15;
          ct_next    = timestamp;
          dirty_next = tssc_pkg::DIRTY_VALUE;
        end
      end
      tssc_pkg::ACT_EMIT: begin
        if (dirty == tssc_pkg::DIRTY_CLEAN) begin
          err = tssc_pkg::ERR_OK;
        end else if (!enabled) begin
          // disabled channel reports the bad state
          if (pv) err = tssc_pkg::ERR_EV_DISABLED;
          else if (dirty == tssc_pkg::DIRTY_VALUE && lev && le == top_st)
            err = tssc_pkg::ERR_REPEAT;
          else begin
            dirty_next = tssc_pkg::DIRTY_CLEAN;
            rec_st     = !lev || (le != top_st);
          end
        end else if (pv) begin
          // event one tick before the change, then the top
          if (dirty == tssc_pkg::DIRTY_VALUE && ((lev && le == pe) || pe == top_st))
            err = tssc_pkg::ERR_REPEAT;
          else begin
            dirty_next = tssc_pkg::DIRTY_CLEAN;
            pv_next    = 1'b0;
            rec_ev     = !lev || (le != pe);
            rec_st     = (pe != top_st);
          end
        end else begin
          if (dirty == tssc_pkg::DIRTY_VALUE && lev && le == top_st)
            err = tssc_pkg::ERR_REPEAT;
          else begin
            dirty_next = tssc_pkg::DIRTY_CLEAN;
            rec_st     = !lev || (le != top_st);
          end
        end
        if (rec_st) begin
          lev_next = 1'b1;
          le_next  = top_st;
        end else if (rec_ev) begin
          lev_next = 1'b1;
          le_next  = pe;
        end
      end
      default: begin
        err = tssc_pkg::ERR_OK;
      end
    endcase
  end

  // current state after the action
  always_comb begin
    if (!enabled_next) begin
      top_new = bad_state;
    end else if (depth_next == '0) begin
      top_new = '0;
    end else begin
      case (sop)
        tssc_pkg::SOP_SET, tssc_pkg::SOP_PUSH: top_new = v15;
        tssc_pkg::SOP_POP:                     top_new = stack[1];
        default:                               top_new = stack[0];
      endcase
    end
  end

  // result pair
  always_comb begin
    res.two       = rec_ev && rec_st;
    res.is_record = rec_ev || rec_st;
    res.err       = err;
    res.cur       = top_new;
    res.t0        = rec_ev ? t_ev : (rec_st ? t_st : '0);
    res.s0        = rec_ev ? pe : (rec_st ? top_st : '0);
    res.t1        = t_st;
    res.s1        = top_st;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst || reload) begin
      stack[0] <= ld.initial_state;
      depth    <= tssc_pkg::DEPTH_W'(1);
      enabled  <= ld.initial_enabled;
      dirty    <= ld.initial_dirty ? tssc_pkg::DIRTY_ACTIVE : tssc_pkg::DIRTY_CLEAN;
      pv       <= 1'b0;
      pe       <= '0;
      ct       <= '0;
      lev      <= 1'b0;
      le       <= '0;
    end else if (fire) begin
      depth   <= depth_next;
      enabled <= enabled_next;
      dirty   <= dirty_next;
      pv      <= pv_next;
      pe      <= pe_next;
      ct      <= ct_next;
      lev     <= lev_next;
      le      <= le_next;
      case (sop)
        tssc_pkg::SOP_SET: begin
          stack[0] <= v15;
        end
        tssc_pkg::SOP_PUSH: begin
          stack[0] <= v15;
          for (int i = 1; i < tssc_pkg::STACK_DEPTH; i++) stack[i] <= stack[i-1];
        end
        tssc_pkg::SOP_POP: begin
          for (int i = 0; i < tssc_pkg::STACK_DEPTH - 1; i++) stack[i] <= stack[i+1];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> tb/sv/trace_channel_checker.sv
// Result checker for the trace state stack channel testbench: predicts every
// result beat from the accepted actions and register writes and compares them.
// Depends on tssc_pkg for widths, actions, error codes and register indexes.
`timescale 1ns / 1ps

module trace_channel_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [2:0]                          action,
  input  logic signed [tssc_pkg::VALUE_W-1:0] state_value,
  input  logic [tssc_pkg::TS_W-1:0]           timestamp,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                is_record,
  input  logic [3:0]                          error_code,
  input  logic [tssc_pkg::STATE_W-1:0]        current_state,
  input  logic signed [tssc_pkg::TIME_W-1:0]  record_time,
  input  logic [tssc_pkg::STATE_W-1:0]        record_state,
  input  logic [tssc_pkg::ROW_W-1:0]          record_row,
  input  logic [tssc_pkg::ROW_W-1:0]          record_type,
  input  logic                                last_result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [tssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tssc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  beat_count,
  output int                                  record_count
);

  import tssc_pkg::*;

  typedef struct packed {
    logic               is_rec;
    logic [3:0]         err;
    logic [STATE_W-1:0] cur;
    logic [TIME_W-1:0]  rtime;
    logic [STATE_W-1:0] rstate;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   typ;
    logic               last;
  } result_beat_t;

  result_beat_t expected_beats[$];

  // register copies
  logic [STATE_W-1:0] bad_st, init_st;
  logic               init_en, init_dirty;
  logic [ROW_W-1:0]   row_reg, type_reg;

  // channel copy
  logic [STATE_W-1:0] stk [STACK_DEPTH];
  logic [4:0]         depth;
  logic               ena;
  tssc_dirty_e        dirty;
  int                 pend_ev;
  logic [TIME_W-1:0]  chg_time;
  int                 last_out;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    beat_count    = 0;
    record_count  = 0;
  end

  // channel state as after reset or an initial register write
  task automatic reload_channel();
    for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
    stk[0]   = init_st;
    depth    = 5'd1;
    ena      = init_en;
    dirty    = init_dirty ? DIRTY_ACTIVE : DIRTY_CLEAN;
    pend_ev  = -1;
    chg_time = '0;
    last_out = -1;
  endtask

  function automatic logic [STATE_W-1:0] shown_state();
    if (!ena) return bad_st;
    if (depth == 0 || depth > STACK_DEPTH) return '0;
    return stk[4'(depth - 5'd1)];
  endfunction

  function automatic logic repeats_last(int last, logic [STATE_W-1:0] st);
    return dirty == DIRTY_VALUE && last != -1 && last == int'(st);
  endfunction

  task automatic add_beat(logic rec, tssc_err_e err, logic [TIME_W-1:0] t,
                          logic [STATE_W-1:0] st, logic last_flag);
    result_beat_t b;
    b.is_rec = rec;
    b.err    = err;
    b.cur    = shown_state();
    b.rtime  = rec ? t : '0;
    b.rstate = rec ? st : '0;
    b.row    = rec ? row_reg : '0;
    b.typ    = rec ? type_reg : '0;
    b.last   = last_flag;
    expected_beats.push_back(b);
  endtask

  // all checks happen before any change; a failed rule leaves state alone
  function automatic tssc_err_e apply_action(logic [2:0] act, logic signed [15:0] v,
                                             logic [TS_W-1:0] ts);
    int                 val;
    logic               want;
    logic [STATE_W-1:0] below;
    val = v;
    case (tssc_act_e'(act))
      ACT_ENABLE, ACT_DISABLE: begin
        want = (act == ACT_ENABLE);
        if (ena == want) return ERR_SAME_ENABLE;
        ena      = want;
        chg_time = {1'b0, ts};
        if (dirty == DIRTY_CLEAN) dirty = DIRTY_ACTIVE;
        return ERR_OK;
      end
      ACT_SET: begin
        if (!ena) return ERR_DISABLED;
        if (val < 0) return ERR_BAD_VALUE;
        if (dirty != DIRTY_ACTIVE && last_out >= 0 && last_out == val) return ERR_REPEAT;
        if (depth == 0) depth = 5'd1;
        stk[4'(depth - 5'd1)] = val[STATE_W-1:0];
        chg_time = {1'b0, ts};
        if (dirty == DIRTY_CLEAN) dirty = DIRTY_VALUE;
        return ERR_OK;
      end
      ACT_PUSH: begin
        if (!ena) return ERR_DISABLED;
        if (val <= 0) return ERR_BAD_VALUE;
        if (dirty != DIRTY_CLEAN) return ERR_DIRTY;
        if (last_out >= 0 && last_out == val) return ERR_REPEAT;
        if (depth >= STACK_DEPTH) return ERR_FULL;
        stk[depth[3:0]] = val[STATE_W-1:0];
        depth    = depth + 5'd1;
        chg_time = {1'b0, ts};
        dirty    = DIRTY_VALUE;
        return ERR_OK;
      end
      ACT_POP: begin
        if (!ena) return ERR_DISABLED;
        if (dirty != DIRTY_CLEAN) return ERR_DIRTY;
        if (depth == 0) return ERR_EMPTY;
        if (val >= 0 && int'(stk[4'(depth - 5'd1)]) != val) return ERR_MISMATCH;
        below = (depth >= 2) ? stk[4'(depth - 5'd2)] : '0;
        if (last_out >= 0 && last_out == int'(below)) return ERR_REPEAT;
        depth    = depth - 5'd1;
        chg_time = {1'b0, ts};
        dirty    = DIRTY_VALUE;
        return ERR_OK;
      end
      ACT_EVENT: begin
        if (!ena) return ERR_DISABLED;
        if (dirty != DIRTY_CLEAN) return ERR_DIRTY;
        if (val <= 0) return ERR_BAD_VALUE;
        if (last_out >= 0 && last_out == val) return ERR_REPEAT;
        pend_ev  = val;
        chg_time = {1'b0, ts};
        dirty    = DIRTY_VALUE;
        return ERR_OK;
      end
      default: return ERR_OK;
    endcase
  endfunction

  // emit: bad state when disabled, else pending event then top, else top
  task automatic emit_records();
    logic [TIME_W-1:0]  rt [2];
    logic [STATE_W-1:0] rs [2];
    logic [STATE_W-1:0] ev, st;
    int                 n, after;
    n = 0;
    if (dirty == DIRTY_CLEAN) begin
      add_beat(1'b0, ERR_OK, '0, '0, 1'b1);
      return;
    end
    st = shown_state();
    if (!ena) begin
      if (pend_ev != -1) begin
        add_beat(1'b0, ERR_EV_DISABLED, '0, '0, 1'b1);
        return;
      end
      if (repeats_last(last_out, st)) begin
        add_beat(1'b0, ERR_REPEAT, '0, '0, 1'b1);
        return;
      end
      dirty = DIRTY_CLEAN;
    end else if (pend_ev != -1) begin
      ev    = pend_ev[STATE_W-1:0];
      after = (int'(ev) != last_out) ? int'(ev) : last_out;
      if (repeats_last(last_out, ev) || repeats_last(after, st)) begin
        add_beat(1'b0, ERR_REPEAT, '0, '0, 1'b1);
        return;
      end
      dirty   = DIRTY_CLEAN;
      pend_ev = -1;
      if (int'(ev) != last_out) begin
        last_out = ev;
        rt[n]    = chg_time - 64'd1;
        rs[n]    = ev;
        n++;
      end
    end else begin
      if (repeats_last(last_out, st)) begin
        add_beat(1'b0, ERR_REPEAT, '0, '0, 1'b1);
        return;
      end
      dirty = DIRTY_CLEAN;
    end
    // the top (or bad state) record, unless it repeats what went out last
    if (int'(st) != last_out) begin
      last_out = st;
      rt[n]    = chg_time;
      rs[n]    = st;
      n++;
    end
    if (n == 0) add_beat(1'b0, ERR_OK, '0, '0, 1'b1);
    for (int k = 0; k < n; k++) add_beat(1'b1, ERR_OK, rt[k], rs[k], k == n - 1);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (tssc_cfg_idx_e'(idx))
      CFG_BAD_STATE:       bad_st = data[STATE_W-1:0];
      CFG_INITIAL_STATE:   begin init_st = data[STATE_W-1:0]; reload_channel(); end
      CFG_INITIAL_ENABLED: begin init_en = data[0]; reload_channel(); end
      CFG_INITIAL_DIRTY:   begin init_dirty = data[0]; reload_channel(); end
      CFG_TRACE_ROW:       row_reg = data;
      CFG_TRACE_TYPE:      type_reg = data;
      default: ;
    endcase
  endtask

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, got %0h", name, want, got);
    return 1;
  endfunction

  // compare the result beat first: it belongs to an earlier item than any
  // action accepted at the same edge
  always @(posedge clk) begin
    result_beat_t e;
    if (rst) begin
      bad_st     = RST_BAD_STATE;
      init_st    = RST_INITIAL_STATE;
      init_en    = RST_INITIAL_ENABLED;
      init_dirty = RST_INITIAL_DIRTY;
      row_reg    = RST_TRACE_ROW;
      type_reg   = RST_TRACE_TYPE;
      reload_channel();
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        beat_count++;
        if (is_record) record_count++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing outstanding: record %0b state %0h",
                 is_record, record_state);
          fail_count++;
        end else begin
          e = expected_beats.pop_front();
          fail_count += field_diff("is_record", e.is_rec, is_record)
                      + field_diff("error_code", e.err, error_code)
                      + field_diff("current_state", e.cur, current_state)
                      + field_diff("record_time", e.rtime, record_time)
                      + field_diff("record_state", e.rstate, record_state)
                      + field_diff("record_row", e.row, record_row)
                      + field_diff("record_type", e.typ, record_type)
                      + field_diff("last_result", e.last, last_result);
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (action == ACT_EMIT) emit_records();
        else add_beat(1'b0, apply_action(action, state_value, timestamp), '0, '0, 1'b1);
      end
    end
    pending_count = expected_beats.size();
  end

endmodule

>>> tb/sv/trace_state_stack_channel_top_tb.sv
// Testbench top for trace_state_stack_channel_top: clock, reset, action and
// register stimulus, output back-pressure, watchdog and verdict.
// Depends on tssc_pkg, trace_state_stack_channel_top and trace_channel_checker.
`timescale 1ns / 1ps

module trace_state_stack_channel_top_tb;

  import tssc_pkg::*;

  localparam int                   STALL_LIMIT = 3000;
  localparam int                   HOLD_CYCLES = 60;
  localparam logic [2:0]           ACT_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
  localparam logic [TS_W-1:0]      TS_MAX      = {TS_W{1'b1}};

  logic                       clk, rst;
  logic                       in_valid, in_ready;
  logic [2:0]                 action;
  logic signed [VALUE_W-1:0]  state_value;
  logic [TS_W-1:0]            timestamp;
  logic                       out_valid, out_ready;
  logic                       is_record, last_result;
  logic [3:0]                 error_code;
  logic [STATE_W-1:0]         current_state, record_state;
  logic signed [TIME_W-1:0]   record_time;
  logic [ROW_W-1:0]           record_row, record_type;
  logic                       cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int fail_count, pending_count, beat_count, record_count;
  int items_sent, stall_cycles;
  int send_idle_pct, recv_idle_pct;
  logic hold_req, hold_taken;
  logic [TS_W-1:0] ts_base;

  trace_state_stack_channel_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .state_value(state_value), .timestamp(timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_record(is_record), .error_code(error_code), .current_state(current_state),
    .record_time(record_time), .record_state(record_state),
    .record_row(record_row), .record_type(record_type), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trace_channel_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .state_value(state_value), .timestamp(timestamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_record(is_record), .error_code(error_code), .current_state(current_state),
    .record_time(record_time), .record_state(record_state),
    .record_row(record_row), .record_type(record_type), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .beat_count(beat_count), .record_count(record_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles in which no channel moves a beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("trace_state_stack_channel_top verification failed");
        $finish;
      end
    end
  end

  // one action beat; called and returns at a falling edge
  task automatic send_beat(input logic [2:0] a, input logic signed [15:0] v,
                           input logic [TS_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= a;
    state_value <= v;
    timestamp   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // register beat; caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [TS_W-1:0] next_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(99) < 10) return r[TS_W-1:0];
    ts_base = ts_base + $urandom_range(1000);
    return ts_base;
  endfunction

  // mode 0 grows the stack, mode 1 drains it, mode 2 mixes
  function automatic logic [2:0] pick_action(int mode);
    int r;
    r = $urandom_range(99);
    if (r < 6) return ACT_DISABLE;
    if (r < 18) return ACT_ENABLE;
    r = $urandom_range(99);
    case (mode)
      0: return (r < 60) ? ACT_PUSH : (r < 70) ? ACT_POP : (r < 85) ? ACT_SET : ACT_EVENT;
      1: return (r < 60) ? ACT_POP : (r < 70) ? ACT_PUSH : (r < 85) ? ACT_SET : ACT_EVENT;
      default: return (r < 35) ? ACT_PUSH : (r < 65) ? ACT_POP : (r < 85) ? ACT_SET : ACT_EVENT;
    endcase
  endfunction

  // small pool so repeats and pop matches happen often
  function automatic logic signed [15:0] pick_value(logic [2:0] a);
    int r;
    r = $urandom_range(99);
    if (a == ACT_POP) begin
      if (r < 50) return -16'sd1;
      if (r < 90) return 16'($urandom_range(1, 6));
      return 16'($urandom_range(65535));
    end
    if (r < 5) return -16'sd1;
    if (r < 10) return 16'sd0;
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 90) return 16'(32767 - $urandom_range(3));
    return 16'($urandom_range(65535));
  endfunction

  // mostly action-then-emit pairs, some lone random beats as noise
  task automatic random_run(input int n_items);
    int         sent, mode, seg;
    logic [2:0] a;
    sent = 0;
    seg  = 0;
    mode = 2;
    while (sent < n_items) begin
      if (seg == 0) begin
        mode = $urandom_range(2);
        seg  = $urandom_range(10, 40);
      end
      seg--;
      if ($urandom_range(99) < 80) begin
        a = pick_action(mode);
        send_beat(a, pick_value(a), next_stamp());
        send_beat(ACT_EMIT, pick_value(ACT_EMIT), next_stamp());
        sent += 2;
      end else begin
        send_beat(3'($urandom_range(7)), 16'($urandom_range(65535)), next_stamp());
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_EMIT;
    state_value   = '0;
    timestamp     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_BAD_STATE;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    hold_taken    = 1'b0;
    items_sent    = 0;
    ts_base       = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: default registers, every action, and every error path but full and empty
    send_beat(ACT_EMIT,    16'sd0,      63'd5);   // clean channel
    send_beat(ACT_ENABLE,  16'sd0,      63'd6);   // already enabled
    send_beat(ACT_PUSH,    16'sd0,      63'd7);   // zero push rejected
    send_beat(ACT_SET,     -16'sd32768, 63'd8);   // negative set rejected
    send_beat(ACT_PUSH,    16'sd32767,  63'd0);
    send_beat(ACT_PUSH,    16'sd5,      63'd9);   // still dirty
    send_beat(ACT_EMIT,    16'sd0,      63'd10);
    send_beat(ACT_EVENT,   16'sd7,      TS_MAX);
    send_beat(ACT_EMIT,    -16'sd1,     63'd11);  // event then top record
    send_beat(ACT_POP,     16'sd100,    63'd12);  // top mismatch
    send_beat(ACT_POP,     -16'sd1,     63'd13);
    send_beat(ACT_EMIT,    16'sd0,      63'd14);
    send_beat(ACT_SET,     16'sd0,      63'd15);  // repeats last record
    send_beat(ACT_DISABLE, 16'sd0,      63'd1);
    send_beat(ACT_SET,     16'sd3,      63'd16);  // disabled
    send_beat(ACT_DISABLE, 16'sd0,      63'd17);  // already disabled
    send_beat(ACT_EMIT,    16'sd0,      63'd18);  // bad state equals last, suppressed
    send_beat(ACT_ENABLE,  16'sd0,      63'd2);
    send_beat(ACT_EMIT,    16'sd0,      63'd19);
    send_beat(ACT_EVENT,   16'sd4,      63'd20);
    send_beat(ACT_DISABLE, 16'sd0,      63'd21);
    send_beat(ACT_EMIT,    16'sd0,      63'd22);  // event pending while disabled
    send_beat(ACT_ENABLE,  16'sd0,      63'd0);
    send_beat(ACT_EMIT,    16'sd0,      63'd23);
    send_beat(ACT_UNUSED,  -16'sd1,     TS_MAX);
    wait_results_done();

    // registers at their upper extremes, channel starts disabled and dirty
    write_reg(CFG_BAD_STATE,       16'hFFFF);
    write_reg(CFG_INITIAL_STATE,   16'h7FFF);
    write_reg(CFG_INITIAL_ENABLED, 16'hFFFE);
    write_reg(CFG_INITIAL_DIRTY,   16'h0001);
    write_reg(CFG_TRACE_ROW,       16'hFFFF);
    write_reg(CFG_TRACE_TYPE,      16'hFFFF);
    write_reg(CFG_UNUSED,          16'($urandom_range(65535)));
    cfg_valid <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 75;
    random_run(210);
    wait_results_done();

    // registers at their lower extremes, trace type random
    write_reg(CFG_BAD_STATE,       16'h0000);
    write_reg(CFG_TRACE_ROW,       16'h0000);
    write_reg(CFG_TRACE_TYPE,      16'($urandom_range(65535)));
    write_reg(CFG_INITIAL_ENABLED, 16'h0001);
    write_reg(CFG_INITIAL_DIRTY,   16'h0000);
    write_reg(CFG_INITIAL_STATE,   16'h8000);
    cfg_valid <= 1'b0;
    send_idle_pct = 75;
    recv_idle_pct = 8;
    random_run(100);
    wait_results_done();
    random_run(110);
    wait_results_done();

    // random register values, long output hold-off at the start
    write_reg(CFG_BAD_STATE,       16'($urandom_range(65535)));
    write_reg(CFG_TRACE_ROW,       16'($urandom_range(65535)));
    write_reg(CFG_TRACE_TYPE,      16'($urandom_range(65535)));
    write_reg(CFG_INITIAL_ENABLED, 16'h0001);
    write_reg(CFG_INITIAL_DIRTY,   16'h0001);
    write_reg(CFG_INITIAL_STATE,   16'($urandom_range(1, 32767)));
    cfg_valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_run(210);
    wait_results_done();
    repeat (8) @(negedge clk);

    $display("summary: %0d actions accepted under four register settings, %0d result beats",
             items_sent, beat_count);
    $display("summary: %0d trace records, with sender stalls, receiver stalls and a full hold-off",
             record_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("trace_state_stack_channel_top verification clean");
    end else begin
      $display("trace_state_stack_channel_top verification failed");
    end
    $finish;
  end

endmodule
